// ===== design/wkalarm_pkg.sv =====
// ----------------------------------------------------------------------------
// wkalarm_pkg
// Shared types, constants and helpers for the weekly alarm unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wkalarm_pkg;

   // Register file geometry.
   localparam int REG_COUNT         = 5;
   localparam int ALARM_SLOTS_DEF   = 5;
   localparam int ALARM_W           = 19;
   localparam int CSR_IDX_W         = 3;
   localparam int SLOT_W            = 3;
   localparam int DAY_W             = 3;

   // Time arithmetic: minutes of the week fit in 14 bits, distances in 15.
   localparam int TIME_W            = 14;
   localparam int DIST_W            = 15;
   localparam logic [TIME_W-1:0] MIN_PER_DAY  = 14'd1440;
   localparam logic [TIME_W-1:0] MIN_PER_HOUR = 14'd60;
   localparam logic signed [DIST_W:0] WEEK_WRAP = 16'sd10079;
   localparam logic [DIST_W-1:0] FAR_DIST     = 15'h7FFF;
   localparam logic [DAY_W-1:0]  LAST_DAY     = 3'd6;

   // Command codes.
   localparam logic [1:0] CMD_TICK      = 2'd0;
   localparam logic [1:0] CMD_RECOMPUTE = 2'd1;
   localparam logic [1:0] CMD_STOP      = 2'd2;

   typedef logic [REG_COUNT-1:0][ALARM_W-1:0] alarm_bank_type;

   typedef struct packed {
      logic [1:0] command;
      logic [4:0] hour_now;
      logic [5:0] minute_now;
      logic [5:0] second_now;
      logic [2:0] weekday_now;
   } req_type;

   typedef struct packed {
      logic       next_valid;
      logic [2:0] next_alarm;
      logic [2:0] next_weekday;
      logic       ringing;
      logic       ring_start;
   } rsp_type;

   // Result of one scan over the alarm/day pairs.
   typedef struct packed {
      logic              done;
      logic              found;
      logic [SLOT_W-1:0] index;
      logic [DAY_W-1:0]  day;
   } scan_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Alarm register fields.
   function automatic logic [5:0] alarm_minute(input logic [ALARM_W-1:0] a);
      return a[5:0];
   endfunction

   function automatic logic [4:0] alarm_hour(input logic [ALARM_W-1:0] a);
      return a[10:6];
   endfunction

   function automatic logic [6:0] alarm_mask(input logic [ALARM_W-1:0] a);
      return a[17:11];
   endfunction

   function automatic logic alarm_enable(input logic [ALARM_W-1:0] a);
      return a[18];
   endfunction

   // Weekday bit test; weekday seven matches no bit.
   function automatic logic day_on(input logic [6:0] mask, input logic [DAY_W-1:0] day);
      logic [7:0] ext;
      ext = {1'b0, mask};
      return ext[day];
   endfunction

endpackage

`default_nettype wire

// ===== design/wkalarm_scan.sv =====
// ----------------------------------------------------------------------------
// wkalarm_scan
// Walks all alarm/day pairs, one per cycle, through a single distance unit
// and keeps the nearest one ahead of the current time.
// ----------------------------------------------------------------------------
`default_nettype none

module wkalarm_scan #(
   parameter int ALARM_SLOTS = wkalarm_pkg::ALARM_SLOTS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire [4:0]                      hour_now,
   input  wire [5:0]                      minute_now,
   input  wire [2:0]                      weekday_now,
   input  wire wkalarm_pkg::alarm_bank_type alarm_regs,
   output wkalarm_pkg::scan_res_type      scan_res
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [wkalarm_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic [wkalarm_pkg::DAY_W-1:0]       day_ff, day_in;
   logic [wkalarm_pkg::TIME_W-1:0]      now_ff, now_in;
   logic                                found_ff, found_in;
   logic [wkalarm_pkg::DIST_W-1:0]      best_dist_ff, best_dist_in;
   logic [wkalarm_pkg::SLOT_W-1:0]      best_slot_ff, best_slot_in;
   logic [wkalarm_pkg::DAY_W-1:0]       best_day_ff, best_day_in;

   logic [wkalarm_pkg::ALARM_W-1:0]     cur_alarm;
   logic [wkalarm_pkg::TIME_W-1:0]      at_time;
   logic signed [wkalarm_pkg::DIST_W:0] diff;
   logic signed [wkalarm_pkg::DIST_W:0] wrapped;
   logic [wkalarm_pkg::DIST_W-1:0]      pair_dist;
   logic                                cand;
   logic                                take;
   logic                                last_pair;

   // Shared distance unit: alarm minute-of-week minus now, wrapped once.
   always_comb begin
      cur_alarm = alarm_regs[slot_ff];
      at_time   = wkalarm_pkg::TIME_W'(
                     wkalarm_pkg::TIME_W'(day_ff) * wkalarm_pkg::MIN_PER_DAY
                   + wkalarm_pkg::TIME_W'(wkalarm_pkg::alarm_hour(cur_alarm))
                     * wkalarm_pkg::MIN_PER_HOUR
                   + wkalarm_pkg::TIME_W'(wkalarm_pkg::alarm_minute(cur_alarm)));
      diff      = signed'({2'b00, at_time}) - signed'({2'b00, now_ff});
      wrapped   = diff + wkalarm_pkg::WEEK_WRAP;
      if (diff >= 0) begin
         pair_dist = diff[wkalarm_pkg::DIST_W-1:0];
      end else if (wrapped >= 0) begin
         pair_dist = wrapped[wkalarm_pkg::DIST_W-1:0];
      end else begin
         pair_dist = wkalarm_pkg::FAR_DIST;
      end
      cand      = wkalarm_pkg::alarm_enable(cur_alarm)
               && wkalarm_pkg::day_on(wkalarm_pkg::alarm_mask(cur_alarm), day_ff);
      take      = cand && (!found_ff || (pair_dist < best_dist_ff));
      last_pair = (day_ff == '0) && (slot_ff == '0);
   end

   // Sequencer: highest slot first, day six down to day zero.
   always_comb begin
      busy_in      = busy_ff;
      done_in      = 1'b0;
      slot_in      = slot_ff;
      day_in       = day_ff;
      now_in       = now_ff;
      found_in     = found_ff;
      best_dist_in = best_dist_ff;
      best_slot_in = best_slot_ff;
      best_day_in  = best_day_ff;
      if (start) begin
         busy_in  = 1'b1;
         slot_in  = wkalarm_pkg::SLOT_W'(ALARM_SLOTS - 1);
         day_in   = wkalarm_pkg::LAST_DAY;
         found_in = 1'b0;
         now_in   = wkalarm_pkg::TIME_W'(
                       wkalarm_pkg::TIME_W'(weekday_now) * wkalarm_pkg::MIN_PER_DAY
                     + wkalarm_pkg::TIME_W'(hour_now) * wkalarm_pkg::MIN_PER_HOUR
                     + wkalarm_pkg::TIME_W'(minute_now) + 14'd1);
      end else if (busy_ff) begin
         if (take) begin
            found_in     = 1'b1;
            best_dist_in = pair_dist;
            best_slot_in = slot_ff;
            best_day_in  = day_ff;
         end
         if (last_pair) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (day_ff == '0) begin
            slot_in = slot_ff - 3'd1;
            day_in  = wkalarm_pkg::LAST_DAY;
         end else begin
            day_in = day_ff - 3'd1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Scan datapath.
   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      day_ff       <= day_in;
      now_ff       <= now_in;
      found_ff     <= found_in;
      best_dist_ff <= best_dist_in;
      best_slot_ff <= best_slot_in;
      best_day_ff  <= best_day_in;
   end

   assign scan_res.done  = done_ff;
   assign scan_res.found = found_ff;
   assign scan_res.index = best_slot_ff;
   assign scan_res.day   = best_day_ff;

endmodule

`default_nettype wire

// ===== design/weekly_alarm_next_and_trigger_top.sv =====
// ----------------------------------------------------------------------------
// weekly_alarm_next_and_trigger_top
// Weekly alarm unit: finds the nearest coming alarm and raises the trigger
// when the current time reaches it.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                       Direction  Handshake
//   req      req_valid/req_stall/req_data in         valid, stall
//   rsp      rsp_valid/rsp_stall/rsp_data out        valid, stall
//   csr      csr_we/csr_index/csr_wdata   in         write enable only
//
// A tick that needs no new search passes from evaluation straight to the finish step.
// A recompute or stop, or a tick whose alarm minute has passed, runs a new
// search first: the scan unit visits one alarm/day pair per cycle.
// Input is stalled while an item is in work.
// Reset is synchronous and clears the alarms, the pick and the trigger.
// A stalled result holds in the output register until its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module weekly_alarm_next_and_trigger_top #(
   parameter int ALARM_SLOTS = wkalarm_pkg::ALARM_SLOTS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire wkalarm_pkg::req_type             req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output wkalarm_pkg::rsp_type                  rsp_data,
   input  wire                                   csr_we,
   input  wire [wkalarm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [wkalarm_pkg::ALARM_W-1:0]        csr_wdata
);

   wkalarm_pkg::state_type          state_ff, state_in;
   wkalarm_pkg::alarm_bank_type     alarm_ff;
   wkalarm_pkg::req_type            req_ff;
   wkalarm_pkg::rsp_type            rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [wkalarm_pkg::SLOT_W-1:0]  best_index_ff, best_index_in;
   logic                            best_valid_ff, best_valid_in;
   logic [wkalarm_pkg::DAY_W-1:0]   best_day_ff, best_day_in;
   logic                            triggered_ff, triggered_in;
   logic                            start_flag_ff, start_flag_in;

   wkalarm_pkg::scan_res_type       scan_res;
   logic                            req_xfer;
   logic                            rsp_free;
   logic                            scan_start;
   logic                            need_scan;
   logic [wkalarm_pkg::ALARM_W-1:0] pick_alarm;
   logic                            hit;
   logic                            trig_next;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Tick evaluation against the current pick, and whether a search follows.
   always_comb begin
      pick_alarm = alarm_ff[best_index_ff];
      hit        = best_valid_ff
                && wkalarm_pkg::day_on(wkalarm_pkg::alarm_mask(pick_alarm),
                                       req_ff.weekday_now)
                && (wkalarm_pkg::alarm_hour(pick_alarm) == req_ff.hour_now)
                && (wkalarm_pkg::alarm_minute(pick_alarm) == req_ff.minute_now);
      trig_next  = triggered_ff || (hit && (req_ff.second_now == 6'd0));
      case (req_ff.command)
         wkalarm_pkg::CMD_TICK:      need_scan = trig_next && !hit;
         wkalarm_pkg::CMD_RECOMPUTE: need_scan = 1'b1;
         wkalarm_pkg::CMD_STOP:      need_scan = 1'b1;
         default:                    need_scan = 1'b0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wkalarm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = wkalarm_pkg::ST_EVAL;
            end
         end
         wkalarm_pkg::ST_EVAL: begin
            state_in = need_scan ? wkalarm_pkg::ST_SCAN : wkalarm_pkg::ST_FINISH;
         end
         wkalarm_pkg::ST_SCAN: begin
            if (scan_res.done) begin
               state_in = wkalarm_pkg::ST_FINISH;
            end
         end
         wkalarm_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = wkalarm_pkg::ST_IDLE;
            end
         end
         default: state_in = wkalarm_pkg::ST_IDLE;
      endcase
   end

   // Outputs and state updates of each step.
   always_comb begin
      req_stall     = (state_ff != wkalarm_pkg::ST_IDLE);
      scan_start    = 1'b0;
      best_index_in = best_index_ff;
      best_valid_in = best_valid_ff;
      best_day_in   = best_day_ff;
      triggered_in  = triggered_ff;
      start_flag_in = start_flag_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         wkalarm_pkg::ST_EVAL: begin
            scan_start    = need_scan;
            start_flag_in = 1'b0;
            case (req_ff.command)
               wkalarm_pkg::CMD_TICK: begin
                  triggered_in  = trig_next && hit;
                  start_flag_in = trig_next && hit && !triggered_ff;
               end
               wkalarm_pkg::CMD_STOP: begin
                  triggered_in = 1'b0;
               end
               default: begin
                  triggered_in = triggered_ff;
               end
            endcase
         end
         wkalarm_pkg::ST_SCAN: begin
            if (scan_res.done) begin
               best_valid_in = scan_res.found;
               best_index_in = scan_res.found ? scan_res.index : '0;
               best_day_in   = scan_res.found ? scan_res.day : best_day_ff;
            end
         end
         wkalarm_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.next_valid    = best_valid_ff;
               rsp_in.next_alarm    = best_valid_ff ? best_index_ff : '0;
               rsp_in.next_weekday  = best_valid_ff ? best_day_ff : '0;
               rsp_in.ringing       = triggered_ff;
               rsp_in.ring_start    = start_flag_ff;
            end
         end
         default: begin
            scan_start = 1'b0;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wkalarm_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         best_index_ff <= '0;
         best_valid_ff <= 1'b0;
         best_day_ff   <= '0;
         triggered_ff  <= 1'b0;
         start_flag_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         best_index_ff <= best_index_in;
         best_valid_ff <= best_valid_in;
         best_day_ff   <= best_day_in;
         triggered_ff  <= triggered_in;
         start_flag_ff <= start_flag_in;
      end
   end

   // Alarm registers; writes beyond the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff <= '0;
      end else if (csr_we && (csr_index < wkalarm_pkg::CSR_IDX_W'(wkalarm_pkg::REG_COUNT))) begin
         alarm_ff[csr_index] <= csr_wdata;
      end
   end

   // Input capture and result register.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   wkalarm_scan #(
      .ALARM_SLOTS (ALARM_SLOTS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (scan_start),
      .hour_now    (req_ff.hour_now),
      .minute_now  (req_ff.minute_now),
      .weekday_now (req_ff.weekday_now),
      .alarm_regs  (alarm_ff),
      .scan_res    (scan_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A scan only completes while the sequencer waits for it.
   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_res.done |-> (state_ff == wkalarm_pkg::ST_SCAN))
      else $error("scan completed outside of the scan state");

   // A ring start is only reported together with ringing.
   a_start_rings: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.ring_start) |-> rsp_ff.ringing)
      else $error("ring start reported without ringing");

   // The pick never names a slot outside the scanned range.
   a_pick_range: assert property (@(posedge clock) disable iff (reset)
      best_valid_ff |-> (best_index_ff <= wkalarm_pkg::SLOT_W'(ALARM_SLOTS - 1)))
      else $error("pick outside the scanned slots");

   // Without a pick the index reads zero.
   a_no_pick_zero: assert property (@(posedge clock) disable iff (reset)
      !best_valid_ff |-> (best_index_ff == '0))
      else $error("index not cleared without a pick");

   // An accepted item always enters evaluation next.
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == wkalarm_pkg::ST_EVAL))
      else $error("accepted item did not enter evaluation");

endmodule

`default_nettype wire
